/* rtl/msm10_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// msm10_pkg: shared types and microcode for the neighborhood-sum automaton
// Word formats, command codes, sequencer step codes, the control-word
// layout with its program table, and the small mod-10 helper.
// ----------------------------------------------------------------------------
package msm10_pkg;

	localparam logic [4:0] DIGIT_BASE  = 5'd10;
	localparam logic [4:0] DIGIT_BASE2 = 5'd20;

	typedef enum logic {
		CMD_ITERATE = 1'b0,
		CMD_READ    = 1'b1
	} cmd_t;

	typedef struct packed {
		cmd_t       cmd;
		logic [3:0] row;
		logic [3:0] column;
	} req_t;

	typedef struct packed {
		logic [3:0] cell_value;
		logic       occupied;
		logic       generation_done;
	} res_t;

	typedef logic [3:0] step_t;

	localparam step_t ST_INIT     = 4'd0;
	localparam step_t ST_IDLE     = 4'd1;
	localparam step_t ST_IT_TM    = 4'd2;
	localparam step_t ST_IT_BOT   = 4'd3;
	localparam step_t ST_IT_ACC   = 4'd4;
	localparam step_t ST_IT_ROW   = 4'd5;
	localparam step_t ST_IT_DONE  = 4'd6;
	localparam step_t ST_RD_ISSUE = 4'd7;
	localparam step_t ST_RD_OUT   = 4'd8;

	typedef enum logic [2:0] {
		JC_NEXT      = 3'd0,
		JC_ALWAYS    = 3'd1,
		JC_INIT_MORE = 3'd2,
		JC_DISPATCH  = 3'd3,
		JC_COL_MORE  = 3'd4,
		JC_ROW_MORE  = 3'd5
	} jump_t;

	typedef enum logic [1:0] {
		AS_REQ = 2'd0,
		AS_TOP = 2'd1,
		AS_BOT = 2'd2
	} asel_t;

	typedef struct packed {
		jump_t jc;
		step_t target;
		asel_t asel;
		logic  init_wr;
		logic  vsum_ld;
		logic  col_acc;
		logic  row_adv;
		logic  out_read;
		logic  out_gen;
	} ctrl_t;

	// Program table: one control word per sequencer step.
	function automatic ctrl_t ucode(input step_t s);
		ctrl_t w;
		w = '0;
		unique case (s)
			ST_INIT: begin
				w.jc      = JC_INIT_MORE;
				w.target  = ST_INIT;
				w.init_wr = 1'b1;
			end
			ST_IDLE: begin
				w.jc     = JC_DISPATCH;
				w.target = ST_RD_ISSUE;
			end
			ST_IT_TM: begin
				w.jc   = JC_NEXT;
				w.asel = AS_TOP;
			end
			ST_IT_BOT: begin
				w.jc      = JC_NEXT;
				w.asel    = AS_BOT;
				w.vsum_ld = 1'b1;
			end
			ST_IT_ACC: begin
				w.jc      = JC_COL_MORE;
				w.target  = ST_IT_TM;
				w.col_acc = 1'b1;
			end
			ST_IT_ROW: begin
				w.jc      = JC_ROW_MORE;
				w.target  = ST_IT_TM;
				w.row_adv = 1'b1;
			end
			ST_IT_DONE: begin
				w.jc      = JC_ALWAYS;
				w.target  = ST_IDLE;
				w.out_gen = 1'b1;
			end
			ST_RD_ISSUE: begin
				w.jc   = JC_NEXT;
				w.asel = AS_REQ;
			end
			ST_RD_OUT: begin
				w.jc       = JC_ALWAYS;
				w.target   = ST_IDLE;
				w.out_read = 1'b1;
			end
			default: begin
				w.jc     = JC_ALWAYS;
				w.target = ST_IDLE;
			end
		endcase
		return w;
	endfunction

	// Remainder by ten for values up to 29.
	function automatic logic [3:0] mod10_small(input logic [4:0] v);
		logic [4:0] r;
		if (v >= DIGIT_BASE2) begin
			r = v - DIGIT_BASE2;
		end else if (v >= DIGIT_BASE) begin
			r = v - DIGIT_BASE;
		end else begin
			r = v;
		end
		return r[3:0];
	endfunction

endpackage
`default_nettype wire

/* rtl/msm10_ram.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// msm10_ram: generic RAM, one write port, two registered read ports
// Plain storage array; read data appears the cycle after the address.
// ----------------------------------------------------------------------------
module msm10_ram #(
	parameter int WIDTH = 4,
	parameter int DEPTH = 512
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
	output      logic [WIDTH-1:0]         rdata_a,
	input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
	output      logic [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_a <= mem_q[raddr_a];
		rdata_b <= mem_q[raddr_b];
	end

endmodule
`default_nettype wire

/* rtl/moore_sum_mod10_automaton.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// moore_sum_mod10_automaton: grid of decimal digits, neighborhood sum mod 10
// Microcoded sequencer over a double-buffered grid RAM.
// ----------------------------------------------------------------------------
// A command word is taken when start is high and busy is low; every command
// returns exactly one result word, shown for one cycle while done is high,
// and the receiver cannot stall it. After reset the block sweeps the grid
// once, writing row times column mod 10 into each cell, and stays busy
// until the sweep ends. A read passes an issue step and an output step
// before its result word is registered. An iterate runs a three-step
// microcode loop for every column of every row and for one flush column
// past the right edge, plus one row step per row, fed by one dual-read-port
// RAM. The new generation goes to the other half of the RAM, and the halves
// swap roles when the iterate finishes. A new command may be taken in the
// cycle in which the previous result is shown.
module moore_sum_mod10_automaton
	import msm10_pkg::*;
#(
	parameter int ROWS    = 16,
	parameter int COLUMNS = 16
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic start,
	input  wire req_t request,
	output      logic busy,
	output      logic done,
	output      res_t result
);

	localparam int Cells = ROWS * COLUMNS;
	localparam int AW    = $clog2(2 * Cells);
	localparam int RW    = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int CW    = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
	localparam int KW    = $clog2(COLUMNS + 1);

	localparam logic [RW-1:0] RowLast   = RW'(ROWS - 1);
	localparam logic [KW-1:0] ColLast   = KW'(COLUMNS - 1);
	localparam logic [KW-1:0] KEnd      = KW'(COLUMNS);
	localparam logic [AW-1:0] BankOfs   = AW'(Cells);
	localparam logic [AW-1:0] ColStride = AW'(COLUMNS);

	function automatic logic [AW-1:0] cell_addr(input logic b, input logic [AW-1:0] rr,
			input logic [AW-1:0] cc);
		return (b ? BankOfs : '0) + rr * ColStride + cc;
	endfunction

	step_t          step_q;
	step_t          step_d;
	ctrl_t          cw;
	logic [RW-1:0]  r_q;
	logic [KW-1:0]  k_q;
	logic [3:0]     iv_q;
	logic [3:0]     rm_q;
	logic           bank_q;
	logic [3:0]     cs0_q;
	logic [3:0]     cs1_q;
	logic [4:0]     vsum_q;
	logic [3:0]     req_row_q;
	logic [3:0]     req_col_q;
	logic           in_range_q;
	res_t           res_q;
	logic           done_q;

	logic           accept;
	logic           init_col_end;
	logic           init_last;
	logic [CW-1:0]  kc;
	logic [KW-1:0]  km1;
	logic [RW-1:0]  r_top;
	logic [RW-1:0]  r_bot;
	logic           has_top;
	logic           has_bot;
	logic [4:0]     colsum;
	logic [3:0]     coldig;
	logic [3:0]     new_digit;
	logic [3:0]     rd_digit;
	logic [AW-1:0]  req_addr;
	logic [AW-1:0]  raddr_a;
	logic [AW-1:0]  raddr_b;
	logic           ram_we;
	logic [AW-1:0]  ram_waddr;
	logic [3:0]     ram_wdata;
	logic [3:0]     rdata_a;
	logic [3:0]     rdata_b;

	assign cw     = ucode(step_q);
	assign busy   = (step_q != ST_IDLE);
	assign accept = start && (step_q == ST_IDLE);

	assign init_col_end = (k_q == ColLast);
	assign init_last    = init_col_end && (r_q == RowLast);

	// The flush column past the right edge reads column zero and is masked.
	assign kc      = (k_q == KEnd) ? '0 : k_q[CW-1:0];
	assign km1     = k_q - 1'b1;
	assign has_top = (r_q != '0);
	assign has_bot = (r_q != RowLast);
	assign r_top   = has_top ? RW'(r_q - 1'b1) : r_q;
	assign r_bot   = has_bot ? RW'(r_q + 1'b1) : r_q;

	assign colsum    = (k_q == KEnd) ? 5'd0 : vsum_q + (has_bot ? {1'b0, rdata_a} : 5'd0);
	assign coldig    = mod10_small(colsum);
	assign new_digit = mod10_small({1'b0, cs0_q} + {1'b0, cs1_q} + {1'b0, coldig});
	assign rd_digit  = in_range_q ? rdata_a : 4'd0;

	assign req_addr = in_range_q ? cell_addr(bank_q, AW'(req_row_q), AW'(req_col_q)) : '0;

	always_comb begin
		unique case (cw.asel)
			AS_REQ:  raddr_a = req_addr;
			AS_TOP:  raddr_a = cell_addr(bank_q, AW'(r_top), AW'(kc));
			AS_BOT:  raddr_a = cell_addr(bank_q, AW'(r_bot), AW'(kc));
			default: raddr_a = req_addr;
		endcase
	end
	assign raddr_b = cell_addr(bank_q, AW'(r_q), AW'(kc));

	assign ram_we    = cw.init_wr || (cw.col_acc && (k_q != '0));
	assign ram_waddr = cw.init_wr ? cell_addr(1'b0, AW'(r_q), AW'(k_q[CW-1:0]))
		: cell_addr(~bank_q, AW'(r_q), AW'(km1[CW-1:0]));
	assign ram_wdata = cw.init_wr ? iv_q : new_digit;

	msm10_ram #(
		.WIDTH(4),
		.DEPTH(2 * Cells)
	) u_ram (
		.clk     (clk),
		.we      (ram_we),
		.waddr   (ram_waddr),
		.wdata   (ram_wdata),
		.raddr_a (raddr_a),
		.rdata_a (rdata_a),
		.raddr_b (raddr_b),
		.rdata_b (rdata_b)
	);

	always_comb begin
		unique case (cw.jc)
			JC_NEXT:      step_d = step_t'(step_q + 1'b1);
			JC_ALWAYS:    step_d = cw.target;
			JC_INIT_MORE: step_d = init_last ? step_t'(step_q + 1'b1) : cw.target;
			JC_DISPATCH: begin
				if (!start) begin
					step_d = step_q;
				end else if (request.cmd == CMD_READ) begin
					step_d = cw.target;
				end else begin
					step_d = step_t'(step_q + 1'b1);
				end
			end
			JC_COL_MORE:  step_d = (k_q != KEnd) ? cw.target : step_t'(step_q + 1'b1);
			JC_ROW_MORE:  step_d = (r_q != RowLast) ? cw.target : step_t'(step_q + 1'b1);
			default:      step_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= ST_INIT;
			r_q    <= '0;
			k_q    <= '0;
			iv_q   <= 4'd0;
			rm_q   <= 4'd0;
			bank_q <= 1'b0;
			cs0_q  <= 4'd0;
			cs1_q  <= 4'd0;
			done_q <= 1'b0;
		end else begin
			step_q <= step_d;
			done_q <= cw.out_read || cw.out_gen;
			if (cw.init_wr) begin
				// Walk the grid once; each column step adds the row's residue.
				if (init_col_end) begin
					k_q  <= '0;
					iv_q <= 4'd0;
					rm_q <= (rm_q == 4'd9) ? 4'd0 : 4'(rm_q + 1'b1);
					r_q  <= (r_q == RowLast) ? '0 : RW'(r_q + 1'b1);
				end else begin
					k_q  <= KW'(k_q + 1'b1);
					iv_q <= mod10_small({1'b0, iv_q} + {1'b0, rm_q});
				end
			end
			if (cw.col_acc) begin
				cs0_q <= cs1_q;
				cs1_q <= coldig;
				if (k_q != KEnd) begin
					k_q <= KW'(k_q + 1'b1);
				end
			end
			if (cw.row_adv) begin
				k_q   <= '0;
				cs0_q <= 4'd0;
				cs1_q <= 4'd0;
				r_q   <= (r_q == RowLast) ? '0 : RW'(r_q + 1'b1);
			end
			if (cw.out_gen) begin
				bank_q <= ~bank_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_row_q  <= request.row;
			req_col_q  <= request.column;
			in_range_q <= ({28'd0, request.row} < 32'(ROWS))
				&& ({28'd0, request.column} < 32'(COLUMNS));
		end
		if (cw.vsum_ld) begin
			vsum_q <= (has_top ? {1'b0, rdata_a} : 5'd0) + {1'b0, rdata_b};
		end
		if (cw.out_read) begin
			res_q.cell_value      <= rd_digit;
			res_q.occupied        <= (rd_digit != 4'd0);
			res_q.generation_done <= 1'b0;
		end else if (cw.out_gen) begin
			res_q.cell_value      <= 4'd0;
			res_q.occupied        <= 1'b0;
			res_q.generation_done <= 1'b1;
		end
	end

	assign done   = done_q;
	assign result = res_q;

	a_done_in_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (step_q == ST_IDLE))
		else $error("result word shown while the sequencer is not idle");

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe held for more than one cycle");

	a_col_range: assert property (@(posedge clk) disable iff (!arst_n)
		k_q <= KEnd)
		else $error("column counter ran past the flush column");

	a_bank_swap: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(bank_q) |-> (done && result.generation_done))
		else $error("grid halves swapped without a finished generation");

	a_write_steps: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (step_q == ST_INIT || step_q == ST_IT_ACC))
		else $error("grid RAM written outside the fill or accumulate step");

endmodule
`default_nettype wire
